// ===== hdl/drfft_pkg.sv =====
// Package for the dual real FFT: data types, twiddle table and helpers.
// No dependencies.
package drfft_pkg;

  localparam int VALUE_BITS = 22;
  localparam int POS_BITS   = 6;
  localparam int TW_BITS    = 18;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic signed [TW_BITS-1:0]    tw_t;

  // Q1.16 cosine over one quarter of a circle of 32 steps.
  function automatic tw_t quarter_cos(input logic [3:0] m);
    tw_t r;
    begin
      case (m)
        4'd0: r = 18'sd65536;
        4'd1: r = 18'sd64277;
        4'd2: r = 18'sd60547;
        4'd3: r = 18'sd54491;
        4'd4: r = 18'sd46341;
        4'd5: r = 18'sd36410;
        4'd6: r = 18'sd25080;
        4'd7: r = 18'sd12785;
        default: r = 18'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic tw_t cos_at(input logic [4:0] m);
    tw_t r;
    begin
      if (m <= 5'd8) r = quarter_cos(m[3:0]);
      else if (m <= 5'd16) r = -quarter_cos(4'(5'd16 - m));
      else if (m <= 5'd24) r = -quarter_cos(4'(m - 5'd16));
      else r = quarter_cos(4'(6'd32 - {1'b0, m}));
      return r;
    end
  endfunction

  function automatic tw_t sin_at(input logic [4:0] m);
    return cos_at(5'(m + 5'd24));
  endfunction

endpackage

// ===== hdl/drfft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module drfft_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/dual_real_fft_top.sv =====
// Top level of the dual real FFT: loader, butterfly sequencer and emitter.
// Depends on drfft_pkg and drfft_ram.
//
// Load 2N samples (N = FFT_POINTS): the first N are the real sequence A, the
// next N the real sequence B. They form one complex word A + iB per entry,
// with the real part in one work RAM and the imaginary part in another, at
// bit-reversed addresses. Samples are taken one per cycle (busy stays low)
// until the last of the 2N arrives. Then busy rises while one shared
// butterfly unit sweeps log2(N) stages of N/2 butterflies. Each butterfly
// does two RAM reads, a multiply step, a rounding step and two writes. The
// emitter then makes two passes over k = 0..N/2-1, the first for the real
// words and the second for the imaginary words. Each step does two RAM
// reads and a capture, then issues two words, each a transfer with out_valid
// high. For N = 32 a block holds 64 samples. Busy stays high after the last
// sample until the emitter is done, and no sample of the next block is taken
// before then. The butterfly steps and the RAM read latency set how long a
// block takes. The receiver cannot stall: out_valid marks each word for
// exactly one cycle.
module dual_real_fft_top
  import drfft_pkg::*;
#(
  parameter int FFT_POINTS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  output logic signed [VALUE_BITS-1:0]  out_value,
  output logic [POS_BITS-1:0]           out_position,
  output logic                          out_last
);
  localparam int AW = $clog2(FFT_POINTS);
  localparam int CW = AW + 1;
  localparam int PW = VALUE_BITS + TW_BITS;

  typedef enum logic [3:0] {
    S_LOAD, S_RD_TOP, S_RD_BOT, S_MUL, S_SUM, S_WR_TOP, S_WR_BOT,
    S_E_RDA, S_E_RDB, S_E_CAP, S_E_OUT0, S_E_OUT1
  } state_t;

  state_t        state_r;
  logic [CW-1:0] load_cnt_r;
  logic [AW-1:0] stage_r;
  logic [AW-1:0] bfly_r;
  logic [AW-1:0] k_r;
  logic          hi_pass_r;

  // Work RAMs: real and imaginary halves of each complex entry
  logic          re_we, im_we;
  logic [AW-1:0] waddr, raddr;
  val_t          re_wdata, im_wdata, re_rdata, im_rdata;

  drfft_ram #(.WIDTH(VALUE_BITS), .DEPTH(FFT_POINTS)) u_ram_re (
    .clk, .we(re_we), .waddr, .wdata(re_wdata), .raddr, .rdata(re_rdata)
  );

  drfft_ram #(.WIDTH(VALUE_BITS), .DEPTH(FFT_POINTS)) u_ram_im (
    .clk, .we(im_we), .waddr, .wdata(im_wdata), .raddr, .rdata(im_rdata)
  );

  // Held operands
  val_t a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  val_t t_re_r, t_im_r;
  logic [4:0] tw_idx_r;

  // Bit reversal of the load index
  logic [AW-1:0] ld_idx, ld_rev;
  assign ld_idx = load_cnt_r[AW-1:0];
  always_comb begin
    for (int b = 0; b < AW; b++) ld_rev[b] = ld_idx[AW-1-b];
  end

  // Butterfly addresses: group size 2^(stage+1), half = 2^stage
  logic [AW-1:0] half_mask, j_idx, top_addr, bot_addr;
  assign half_mask = AW'((1 << stage_r) - 1);
  assign j_idx     = bfly_r & half_mask;
  assign top_addr  = AW'(((bfly_r & ~half_mask) << 1) | j_idx);
  assign bot_addr  = AW'(top_addr | (AW'(1) << stage_r));

  logic [AW-1:0] mirror_k;
  assign mirror_k = AW'(0) - k_r;

  function automatic val_t rnd16(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    begin
      s = v + PW'(32768);
      return val_t'(s >>> 16);
    end
  endfunction

  // Halve a full-width sum, rounding ties toward plus infinity.
  function automatic val_t half_rnd(input logic signed [VALUE_BITS:0] v);
    logic signed [VALUE_BITS+1:0] s;
    begin
      s = (VALUE_BITS+2)'(v) + (VALUE_BITS+2)'(1);
      return val_t'(s >>> 1);
    end
  endfunction

  val_t ext_sample;
  assign ext_sample = val_t'(in_sample);

  logic last_load;
  assign last_load = (load_cnt_r == CW'(2*FFT_POINTS-1));

  // Emit words; sums keep their carry bit before the halving
  val_t e_w0, e_w1, e_w2, e_w3;
  logic signed [VALUE_BITS:0] sum_rr, sum_ii, dif_ii, dif_rr;
  assign sum_rr = (VALUE_BITS+1)'(a_re_r) + (VALUE_BITS+1)'(b_re_r);
  assign sum_ii = (VALUE_BITS+1)'(a_im_r) + (VALUE_BITS+1)'(b_im_r);
  assign dif_ii = (VALUE_BITS+1)'(a_im_r) - (VALUE_BITS+1)'(b_im_r);
  assign dif_rr = (VALUE_BITS+1)'(b_re_r) - (VALUE_BITS+1)'(a_re_r);
  always_comb begin
    if (k_r == '0) begin
      e_w0 = a_re_r; e_w1 = a_im_r; e_w2 = b_re_r; e_w3 = b_im_r;
    end else begin
      e_w0 = half_rnd(sum_rr); e_w1 = half_rnd(sum_ii);
      e_w2 = half_rnd(dif_ii); e_w3 = half_rnd(dif_rr);
    end
  end

  logic [POS_BITS-1:0] pos_lo, pos_hi, pos_cur;
  assign pos_lo  = POS_BITS'({k_r, 1'b0});
  assign pos_hi  = POS_BITS'(FFT_POINTS + 2 * int'(k_r));
  assign pos_cur = hi_pass_r ? pos_hi : pos_lo;

  assign busy = (state_r != S_LOAD);

  // RAM port drive
  always_comb begin
    re_we = 1'b0; im_we = 1'b0; waddr = top_addr; raddr = top_addr;
    re_wdata = a_re_r + t_re_r; im_wdata = a_im_r + t_im_r;
    unique case (state_r)
      S_LOAD: begin
        re_we = start && (load_cnt_r < CW'(FFT_POINTS));
        im_we = start && (load_cnt_r >= CW'(FFT_POINTS));
        waddr = ld_rev;
        re_wdata = ext_sample;
        im_wdata = ext_sample;
      end
      S_RD_BOT: raddr = bot_addr;
      S_WR_TOP: begin
        re_we = 1'b1; im_we = 1'b1;
      end
      S_WR_BOT: begin
        re_we = 1'b1; im_we = 1'b1; waddr = bot_addr;
        re_wdata = a_re_r - t_re_r; im_wdata = a_im_r - t_im_r;
      end
      S_E_RDA: raddr = k_r;
      S_E_RDB: raddr = (k_r == '0) ? AW'(FFT_POINTS/2) : mirror_k;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; load_cnt_r <= '0; stage_r <= '0; bfly_r <= '0;
      k_r <= '0; hi_pass_r <= 1'b0; out_valid <= 1'b0; out_last <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      unique case (state_r)
        // Advance the load count on every transfer; wrap after the last sample.
        S_LOAD: begin
          if (start) begin
            load_cnt_r <= last_load ? '0 : CW'(load_cnt_r + CW'(1));
            if (last_load) state_r <= S_RD_TOP;
          end
        end
        S_RD_TOP: state_r <= S_RD_BOT;
        // Hold the top operand; the bottom one arrives next cycle.
        S_RD_BOT: begin
          a_re_r <= re_rdata; a_im_r <= im_rdata;
          tw_idx_r <= 5'(int'(j_idx) << (4 - int'(stage_r)));
          state_r <= S_MUL;
        end
        S_MUL: begin
          p_xc_r <= re_rdata * cos_at(tw_idx_r);
          p_ys_r <= im_rdata * sin_at(tw_idx_r);
          p_yc_r <= im_rdata * cos_at(tw_idx_r);
          p_xs_r <= re_rdata * sin_at(tw_idx_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          t_re_r <= rnd16(p_xc_r) + rnd16(p_ys_r);
          t_im_r <= rnd16(p_yc_r) - rnd16(p_xs_r);
          state_r <= S_WR_TOP;
        end
        S_WR_TOP: state_r <= S_WR_BOT;
        S_WR_BOT: begin
          if (bfly_r == AW'(FFT_POINTS/2 - 1)) begin
            bfly_r <= '0;
            if (stage_r == AW'(AW-1)) begin
              stage_r <= '0; k_r <= '0; hi_pass_r <= 1'b0; state_r <= S_E_RDA;
            end else begin
              stage_r <= stage_r + AW'(1); state_r <= S_RD_TOP;
            end
          end else begin
            bfly_r <= bfly_r + AW'(1); state_r <= S_RD_TOP;
          end
        end
        S_E_RDA: state_r <= S_E_RDB;
        S_E_RDB: begin
          a_re_r <= re_rdata; a_im_r <= im_rdata;
          state_r <= S_E_CAP;
        end
        S_E_CAP: begin
          b_re_r <= re_rdata; b_im_r <= im_rdata;
          state_r <= S_E_OUT0;
        end
        S_E_OUT0: begin
          out_valid <= 1'b1;
          out_value <= hi_pass_r ? e_w2 : e_w0;
          out_position <= pos_cur;
          state_r <= S_E_OUT1;
        end
        // Real words go out in the first pass, imaginary words in the second.
        S_E_OUT1: begin
          out_valid <= 1'b1;
          out_value <= hi_pass_r ? e_w3 : e_w1;
          out_position <= POS_BITS'(pos_cur + POS_BITS'(1));
          if (k_r == AW'(FFT_POINTS/2 - 1)) begin
            k_r <= '0;
            hi_pass_r <= !hi_pass_r;
            out_last <= hi_pass_r;
            state_r <= hi_pass_r ? S_LOAD : S_E_RDA;
          end else begin
            k_r <= k_r + AW'(1);
            state_r <= S_E_RDA;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
